// File: src/vmc_pkg.sv
// vmc_pkg: shared types, codes and constants of the vertex microcode checker
// no dependencies; used by every module under src

package vmc_pkg;

   localparam int MAX_SLOTS_DEF     = 136;
   localparam int NUM_CONSTANTS_DEF = 192;
   localparam int CONST_BITS        = 192;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [7:0] PROG_LEN_RESET = 8'd136;

   // opcodes
   localparam logic [3:0] MAC_NOP           = 4'd0;
   localparam logic [3:0] MAC_MOV           = 4'd1;
   localparam logic [3:0] MAC_ADD           = 4'd3;
   localparam logic [3:0] MAC_MAD           = 4'd4;
   localparam logic [3:0] MAC_ARL           = 4'd13;
   localparam logic [3:0] MAC_FIRST_RESERVD = 4'd14;
   localparam logic [2:0] ILU_NOP           = 3'd0;
   localparam logic [2:0] ILU_FIRST_UNSUPP  = 3'd5;

   // source muxes
   localparam logic [1:0] MUX_NONE  = 2'd0;
   localparam logic [1:0] MUX_TEMP  = 2'd1;
   localparam logic [1:0] MUX_INPUT = 2'd2;
   localparam logic [1:0] MUX_CONST = 2'd3;

   localparam logic [3:0] LAST_TEMP = 4'd12;
   localparam logic [3:0] LAST_DEST = 4'd12;
   localparam logic [3:0] OREG_LIMIT = 4'd13;
   localparam logic [3:0] OREG_HOLE_A = 4'd1;
   localparam logic [3:0] OREG_HOLE_B = 4'd2;
   localparam logic [3:0] OREG_HOLE_C = 4'd7;
   localparam logic [3:0] OREG_HOLE_D = 4'd8;

   // register map
   localparam logic REG_PROGRAM_LENGTH = 1'b0;

   typedef enum logic [3:0] {
      ERR_NONE         = 4'd0,
      ERR_MAC_RESERVED = 4'd1,
      ERR_ILU_UNSUPP   = 4'd2,
      ERR_BAD_DEST     = 4'd3,
      ERR_BAD_TEMP     = 4'd4,
      ERR_CONST_RANGE  = 4'd5,
      ERR_MUX0         = 4'd6,
      ERR_ARL_OUT      = 4'd7,
      ERR_NOP_OUT      = 4'd8,
      ERR_WRITABLE     = 4'd9,
      ERR_BAD_OREG     = 4'd10,
      ERR_NO_FINAL     = 4'd11
   } err_code_type;

   typedef struct packed {
      logic        first_slot;
      logic [31:0] instr_word1;
      logic [31:0] instr_word2;
      logic [31:0] instr_word3;
   } req_type;

   typedef struct packed {
      logic [7:0]  slot_index;
      logic [3:0]  error_code;
      logic        program_done;
      logic        program_ok;
      logic [15:0] used_inputs;
      logic [12:0] used_outputs;
      logic [63:0] used_consts_low;
      logic [63:0] used_consts_mid;
      logic [63:0] used_consts_high;
      logic        relative_reads;
      logic [7:0]  slots_counted;
   } rsp_type;

   // classified instruction handed from front to back
   typedef struct packed {
      logic         first_slot;
      logic         final_bit;
      err_code_type pre_err;
      logic         in_hit;
      logic [3:0]   in_idx;
      logic         const_hit;
      logic [7:0]   const_idx;
      logic         rel_hit;
      logic         out_hit;
      logic [3:0]   out_idx;
   } cls_type;

endpackage

// File: src/vmc_front.sv
// vmc_front: decodes one instruction and applies the legality rules in order
// depends on vmc_pkg

module vmc_front #(
   parameter int NUM_CONSTANTS = vmc_pkg::NUM_CONSTANTS_DEF
) (
   input  vmc_pkg::req_type item,
   output vmc_pkg::cls_type cls
);

   logic [3:0] mac;
   logic [2:0] ilu;
   logic [3:0] mac_mask;
   logic [3:0] ilu_mask;
   logic [3:0] out_mask;
   logic [3:0] dst;
   logic       omux;
   logic       rel;
   logic [7:0] cidx;
   logic [3:0] oreg;
   logic       const_bad;
   logic       bad_oreg;
   logic [1:0] src_mux [3];
   logic [3:0] src_reg [3];
   logic       src_used [3];
   vmc_pkg::err_code_type src_err [3];
   vmc_pkg::err_code_type err;
   logic       in_hit;
   logic       const_hit;
   logic       rel_hit;

   assign mac      = item.instr_word1[24:21];
   assign ilu      = item.instr_word1[27:25];
   assign cidx     = item.instr_word1[20:13];
   assign mac_mask = item.instr_word3[27:24];
   assign dst      = item.instr_word3[23:20];
   assign ilu_mask = item.instr_word3[19:16];
   assign out_mask = item.instr_word3[15:12];
   assign oreg     = item.instr_word3[6:3];
   assign omux     = item.instr_word3[2];
   assign rel      = item.instr_word3[1];

   assign src_mux[0] = item.instr_word2[27:26];
   assign src_reg[0] = item.instr_word2[31:28];
   assign src_mux[1] = item.instr_word2[12:11];
   assign src_reg[1] = item.instr_word2[16:13];
   assign src_mux[2] = item.instr_word3[29:28];
   assign src_reg[2] = {item.instr_word2[1:0], item.instr_word3[31:30]};

   assign src_used[0] = (mac != vmc_pkg::MAC_NOP);
   assign src_used[1] = (mac != vmc_pkg::MAC_NOP) && (mac != vmc_pkg::MAC_ADD)
                        && (mac != vmc_pkg::MAC_ARL) && (mac != vmc_pkg::MAC_MOV);
   assign src_used[2] = (ilu != vmc_pkg::ILU_NOP) || (mac == vmc_pkg::MAC_ADD)
                        || (mac == vmc_pkg::MAC_MAD);

   assign const_bad = ({1'b0, cidx} >= 9'(NUM_CONSTANTS));
   assign bad_oreg  = (oreg == vmc_pkg::OREG_HOLE_A) || (oreg == vmc_pkg::OREG_HOLE_B)
                      || (oreg == vmc_pkg::OREG_HOLE_C) || (oreg == vmc_pkg::OREG_HOLE_D)
                      || (oreg >= vmc_pkg::OREG_LIMIT);

   always_comb begin
      in_hit    = 1'b0;
      const_hit = 1'b0;
      rel_hit   = 1'b0;
      for (int s = 0; s < 3; s++) begin
         unique case (src_mux[s])
            vmc_pkg::MUX_TEMP: begin
               src_err[s] = (src_reg[s] > vmc_pkg::LAST_TEMP) ? vmc_pkg::ERR_BAD_TEMP
                                                              : vmc_pkg::ERR_NONE;
            end
            vmc_pkg::MUX_INPUT: begin
               src_err[s] = vmc_pkg::ERR_NONE;
            end
            vmc_pkg::MUX_CONST: begin
               src_err[s] = (!rel && const_bad) ? vmc_pkg::ERR_CONST_RANGE
                                                : vmc_pkg::ERR_NONE;
            end
            default: begin
               src_err[s] = vmc_pkg::ERR_MUX0;
            end
         endcase
         if (src_used[s]) begin
            in_hit    = in_hit || (src_mux[s] == vmc_pkg::MUX_INPUT);
            const_hit = const_hit || ((src_mux[s] == vmc_pkg::MUX_CONST) && !rel);
            rel_hit   = rel_hit || ((src_mux[s] == vmc_pkg::MUX_CONST) && rel);
         end
      end
   end

   always_comb begin
      priority if (mac >= vmc_pkg::MAC_FIRST_RESERVD) begin
         err = vmc_pkg::ERR_MAC_RESERVED;
      end else if (ilu >= vmc_pkg::ILU_FIRST_UNSUPP) begin
         err = vmc_pkg::ERR_ILU_UNSUPP;
      end else if ((dst > vmc_pkg::LAST_DEST)
                   && (((mac != vmc_pkg::MAC_NOP) && (mac != vmc_pkg::MAC_ARL)
                        && (mac_mask != 4'd0))
                       || ((ilu != vmc_pkg::ILU_NOP) && (ilu_mask != 4'd0)
                           && (mac == vmc_pkg::MAC_NOP)))) begin
         err = vmc_pkg::ERR_BAD_DEST;
      end else if (src_used[0] && (src_err[0] != vmc_pkg::ERR_NONE)) begin
         err = src_err[0];
      end else if (src_used[1] && (src_err[1] != vmc_pkg::ERR_NONE)) begin
         err = src_err[1];
      end else if (src_used[2] && (src_err[2] != vmc_pkg::ERR_NONE)) begin
         err = src_err[2];
      end else if (out_mask == 4'd0) begin
         err = vmc_pkg::ERR_NONE;
      end else if ((mac == vmc_pkg::MAC_ARL) && !omux) begin
         err = vmc_pkg::ERR_ARL_OUT;
      end else if (omux ? (ilu == vmc_pkg::ILU_NOP) : (mac == vmc_pkg::MAC_NOP)) begin
         err = vmc_pkg::ERR_NOP_OUT;
      end else if (!item.instr_word3[11]) begin
         err = vmc_pkg::ERR_WRITABLE;
      end else if (bad_oreg) begin
         err = vmc_pkg::ERR_BAD_OREG;
      end else begin
         err = vmc_pkg::ERR_NONE;
      end
   end

   always_comb begin
      cls.first_slot = item.first_slot;
      cls.final_bit  = item.instr_word3[0];
      cls.pre_err    = err;
      cls.in_hit     = in_hit;
      cls.in_idx     = item.instr_word1[12:9];
      cls.const_hit  = const_hit;
      cls.const_idx  = cidx;
      cls.rel_hit    = rel_hit;
      cls.out_hit    = (out_mask != 4'd0);
      cls.out_idx    = oreg;
   end

endmodule

// File: src/vmc_queue.sv
// vmc_queue: short queue of classified items between front and back
// depends on vmc_pkg

module vmc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  vmc_pkg::cls_type push_data,
   output logic             full,
   output logic             not_empty,
   input  logic             pop,
   output vmc_pkg::cls_type pop_data
);

   localparam int PW = (vmc_pkg::QUEUE_DEPTH > 1) ? $clog2(vmc_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(vmc_pkg::QUEUE_DEPTH + 1);

   vmc_pkg::cls_type entry_ff [vmc_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff;
   logic [PW-1:0] rd_ptr_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   assign full      = (count_ff == CW'(vmc_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(vmc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(vmc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(vmc_pkg::QUEUE_DEPTH))
      else $error("queue occupancy above depth");

   no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

endmodule

// File: src/vmc_back.sv
// vmc_back: program tracking state, length check and result register
// depends on vmc_pkg

module vmc_back #(
   parameter int MAX_SLOTS     = vmc_pkg::MAX_SLOTS_DEF,
   parameter int NUM_CONSTANTS = vmc_pkg::NUM_CONSTANTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       program_length,
   input  logic             q_valid,
   input  vmc_pkg::cls_type q_data,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vmc_pkg::rsp_type rsp_payload
);

   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam logic [vmc_pkg::CONST_BITS:0] REL_WIDE =
      ((vmc_pkg::CONST_BITS + 1)'(1) << NUM_CONSTANTS) - 1'b1;
   localparam logic [vmc_pkg::CONST_BITS-1:0] REL_MASK = REL_WIDE[vmc_pkg::CONST_BITS-1:0];

   logic [CW-1:0]                   count_ff;
   logic [CW-1:0]                   count_in;
   logic                            ended_ff;
   logic                            ended_in;
   vmc_pkg::err_code_type           fault_ff;
   vmc_pkg::err_code_type           fault_in;
   logic [15:0]                     in_use_ff;
   logic [15:0]                     in_use_in;
   logic [12:0]                     out_use_ff;
   logic [12:0]                     out_use_in;
   logic [vmc_pkg::CONST_BITS-1:0]  const_use_ff;
   logic [vmc_pkg::CONST_BITS-1:0]  const_use_in;
   logic                            rel_ff;
   logic                            rel_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   vmc_pkg::rsp_type                rsp_ff;
   vmc_pkg::rsp_type                rsp_in;

   logic [CW-1:0]                   count_base;
   logic                            ended_base;
   vmc_pkg::err_code_type           fault_base;
   logic [15:0]                     in_use_base;
   logic [12:0]                     out_use_base;
   logic [vmc_pkg::CONST_BITS-1:0]  const_use_base;
   logic                            rel_base;
   logic [CW-1:0]                   count_next;
   logic [CW-1:0]                   slot;
   logic [8:0]                      len_wide;
   logic [8:0]                      len_eff;
   vmc_pkg::err_code_type           err;

   assign q_pop       = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign len_wide    = {1'b0, program_length};

   always_comb begin
      if (len_wide == 9'd0) begin
         len_eff = 9'd1;
      end else if (len_wide > 9'(MAX_SLOTS)) begin
         len_eff = 9'(MAX_SLOTS);
      end else begin
         len_eff = len_wide;
      end
   end

   always_comb begin
      if (q_data.first_slot) begin
         count_base     = '0;
         ended_base     = 1'b0;
         fault_base     = vmc_pkg::ERR_NONE;
         in_use_base    = '0;
         out_use_base   = '0;
         const_use_base = '0;
         rel_base       = 1'b0;
      end else begin
         count_base     = count_ff;
         ended_base     = ended_ff;
         fault_base     = fault_ff;
         in_use_base    = in_use_ff;
         out_use_base   = out_use_ff;
         const_use_base = const_use_ff;
         rel_base       = rel_ff;
      end

      count_next   = count_base + 1'b1;
      err          = q_data.pre_err;
      slot         = '0;
      count_in     = count_base;
      ended_in     = ended_base;
      fault_in     = fault_base;
      in_use_in    = in_use_base;
      out_use_in   = out_use_base;
      const_use_in = const_use_base;
      rel_in       = rel_base;

      if (!ended_base) begin
         if ((err == vmc_pkg::ERR_NONE) && !q_data.final_bit
             && (9'(count_next) >= len_eff)) begin
            err = vmc_pkg::ERR_NO_FINAL;
         end
         slot     = count_base;
         count_in = count_next;
         fault_in = err;
         ended_in = (err != vmc_pkg::ERR_NONE) || q_data.final_bit;
         if (err != vmc_pkg::ERR_NONE) begin
            in_use_in    = '0;
            out_use_in   = '0;
            const_use_in = '0;
            rel_in       = 1'b0;
         end else begin
            if (q_data.in_hit) begin
               in_use_in = in_use_base | (16'd1 << q_data.in_idx);
            end
            if (q_data.out_hit) begin
               out_use_in = out_use_base | (13'd1 << q_data.out_idx);
            end
            if (q_data.const_hit) begin
               const_use_in = const_use_in
                              | (vmc_pkg::CONST_BITS'(1) << q_data.const_idx);
            end
            if (q_data.rel_hit) begin
               const_use_in = const_use_in | REL_MASK;
               rel_in       = 1'b1;
            end
         end
      end

      rsp_in.slot_index       = 8'(slot);
      rsp_in.error_code       = fault_in;
      rsp_in.program_done     = ended_in;
      rsp_in.program_ok       = ended_in && (fault_in == vmc_pkg::ERR_NONE);
      rsp_in.used_inputs      = in_use_in;
      rsp_in.used_outputs     = out_use_in;
      rsp_in.used_consts_low  = const_use_in[63:0];
      rsp_in.used_consts_mid  = const_use_in[127:64];
      rsp_in.used_consts_high = const_use_in[191:128];
      rsp_in.relative_reads   = rel_in;
      rsp_in.slots_counted    = (fault_in == vmc_pkg::ERR_NONE) ? 8'(count_in) : 8'd0;

      rsp_valid_in = q_pop || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ended_ff     <= 1'b0;
         fault_ff     <= vmc_pkg::ERR_NONE;
         in_use_ff    <= '0;
         out_use_ff   <= '0;
         const_use_ff <= '0;
         rel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            count_ff     <= count_in;
            ended_ff     <= ended_in;
            fault_ff     <= fault_in;
            in_use_ff    <= in_use_in;
            out_use_ff   <= out_use_in;
            const_use_ff <= const_use_in;
            rel_ff       <= rel_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   fault_ends_program: assert property (@(posedge clock) disable iff (reset)
      (fault_ff != vmc_pkg::ERR_NONE) |-> ended_ff)
      else $error("fault recorded without program end");

   fault_clears_masks: assert property (@(posedge clock) disable iff (reset)
      (fault_ff != vmc_pkg::ERR_NONE) |-> ((in_use_ff == '0) && (out_use_ff == '0)
                                           && (const_use_ff == '0) && !rel_ff))
      else $error("tracking masks kept after fault");

   count_bound: assert property (@(posedge clock) disable iff (reset)
      (CW + 1)'(count_ff) <= (CW + 1)'(MAX_SLOTS))
      else $error("slot count above maximum");

endmodule

// File: src/vertex_microcode_checker.sv
// vertex_microcode_checker: top level, register port and front/queue/back wiring
// depends on vmc_pkg, vmc_front, vmc_queue, vmc_back
//
// usage:
//   req channel carries one instruction (words 1..3) per item, with first_slot
//   marking the start of a new program; rsp channel returns one result item per
//   instruction: slot number, first error code, program end/ok flags and the
//   running input, output and constant masks.
//   program_length sits at byte address 0 of the register port; write it only
//   while no item is in flight. Reads return its value; pready is always high.
// timing:
//   one item per cycle sustained while rsp_stall is low; an accepted item is
//   written to the queue, then to the result register. The front decode is purely
//   combinational, the two-entry queue takes the item and the back updates
//   tracking state and the result register as it drains the queue.
// reset:
//   clears the queue, the result valid flag and all tracking state; program_length
//   returns to 136.
// stall:
//   a stalled result holds; the queue keeps taking items until both entries are
//   full, then req_stall rises.

module vertex_microcode_checker #(
   parameter int MAX_SLOTS     = vmc_pkg::MAX_SLOTS_DEF,
   parameter int NUM_CONSTANTS = vmc_pkg::NUM_CONSTANTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vmc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vmc_pkg::rsp_type rsp_payload,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [7:0]       len_ff;
   logic [7:0]       len_in;
   logic             reg_write;
   vmc_pkg::cls_type front_cls;
   vmc_pkg::cls_type queue_head;
   logic             queue_full;
   logic             queue_valid;
   logic             queue_pop;
   logic             queue_push;

   assign pready    = 1'b1;
   assign reg_write = psel && penable && pwrite && pready
                      && (paddr[2] == vmc_pkg::REG_PROGRAM_LENGTH);
   assign len_in    = reg_write ? pwdata[7:0] : len_ff;
   assign prdata    = (paddr[2] == vmc_pkg::REG_PROGRAM_LENGTH) ? {24'd0, len_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= vmc_pkg::PROG_LEN_RESET;
      end else begin
         len_ff <= len_in;
      end
   end

   assign req_stall  = queue_full;
   assign queue_push = req_valid && !queue_full;

   vmc_front #(
      .NUM_CONSTANTS(NUM_CONSTANTS)
   ) u_front (
      .item (req_payload),
      .cls  (front_cls)
   );

   vmc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (front_cls),
      .full      (queue_full),
      .not_empty (queue_valid),
      .pop       (queue_pop),
      .pop_data  (queue_head)
   );

   vmc_back #(
      .MAX_SLOTS     (MAX_SLOTS),
      .NUM_CONSTANTS (NUM_CONSTANTS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .program_length (len_ff),
      .q_valid        (queue_valid),
      .q_data         (queue_head),
      .q_pop          (queue_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload)
   );

endmodule
